// ===== sv/sws_pkg.sv =====
// Shared types and constants for the sliding window statistics block.
package sws_pkg;

    localparam int FIELD_W = 24;
    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] LEN_RESET = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_LAUNCH,
        ST_RUN,
        ST_EMIT
    } t_top_state;

    typedef enum logic [2:0] {
        AR_IDLE,
        AR_MDIV,
        AR_SQ,
        AR_NQ,
        AR_VDIV,
        AR_SQRT
    } t_ar_state;

endpackage

// ===== sv/sws_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module sws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/sws_minmax.sv =====
// Window walker: reads entries 0..count-1 and folds minimum and maximum.
module sws_minmax #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_WINDOW  = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sws_pkg::COUNT_W-1:0]   i_count,
    output logic                          o_re,
    output logic [$clog2(MAX_WINDOW)-1:0] o_raddr,
    input  logic [SAMPLE_BITS-1:0]        i_rdata,
    output logic                          o_done,
    output logic [SAMPLE_BITS-1:0]        o_min,
    output logic [SAMPLE_BITS-1:0]        o_max
);
    import sws_pkg::*;

    localparam int PW = $clog2(MAX_WINDOW);

    logic                   r_busy;
    logic                   r_pend;
    logic                   r_first;
    logic                   r_done;
    logic [COUNT_W-1:0]     r_idx;
    logic [COUNT_W-1:0]     r_n;
    logic [SAMPLE_BITS-1:0] r_lo;
    logic [SAMPLE_BITS-1:0] r_hi;
    logic                   issue;

    assign issue   = r_busy && (r_idx < r_n);
    assign o_re    = issue;
    assign o_raddr = PW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_pend  <= 1'b0;
                r_first <= 1'b1;
                r_idx   <= '0;
                r_n     <= i_count;
            end else if (r_busy) begin
                r_pend <= issue;
                if (issue) begin
                    r_idx <= r_idx + COUNT_W'(1);
                end
                if (r_pend) begin
                    r_first <= 1'b0;
                    if (r_first || i_rdata < r_lo) r_lo <= i_rdata;
                    if (r_first || i_rdata > r_hi) r_hi <= i_rdata;
                end
                if (!issue && !r_pend) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_min  = r_lo;
    assign o_max  = r_hi;
endmodule

// ===== sv/sws_arith.sv =====
// Serial mean and standard deviation unit: shift-add multiply, restoring divide, digit root.
module sws_arith #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_WINDOW  = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sws_pkg::COUNT_W-1:0] i_count,
    input  logic [SAMPLE_BITS + $clog2(((MAX_WINDOW < 255) ? MAX_WINDOW : 255) + 1) - 1:0]
                                        i_sum,
    input  logic [2*SAMPLE_BITS + $clog2(((MAX_WINDOW < 255) ? MAX_WINDOW : 255) + 1) - 1:0]
                                        i_sqsum,
    output logic                        o_done,
    output logic [sws_pkg::FIELD_W-1:0] o_mean,
    output logic [sws_pkg::FIELD_W-1:0] o_std
);
    import sws_pkg::*;

    localparam int NMAX = (MAX_WINDOW < 255) ? MAX_WINDOW : 255;
    localparam int LW   = $clog2(NMAX + 1);
    localparam int SW   = SAMPLE_BITS + LW;
    localparam int QW   = 2*SAMPLE_BITS + LW;
    localparam int VW0  = QW + COUNT_W;
    localparam int VW   = VW0 + (VW0 % 2);
    localparam int RW   = VW / 2;
    localparam int DW   = 2*COUNT_W;
    localparam int CNTW = $clog2(VW + 1);

    t_ar_state r_state, n_state;

    logic [COUNT_W-1:0] r_n;
    logic [SW-1:0]      r_s;
    logic [QW-1:0]      r_q;
    logic [VW-1:0]      r_a;
    logic [VW-1:0]      r_b;
    logic [VW-1:0]      r_mcand;
    logic [SW-1:0]      r_mplier;
    logic [VW-1:0]      r_v;
    logic [DW-1:0]      r_rem;
    logic [DW-1:0]      r_d;
    logic [RW+1:0]      r_srem;
    logic [RW-1:0]      r_root;
    logic [CNTW-1:0]    r_cnt;
    logic [FIELD_W-1:0] r_mean;
    logic [FIELD_W-1:0] r_std;
    logic               r_done;

    logic               last;
    logic [VW-1:0]      n_a;
    logic [DW:0]        dv_t;
    logic               dv_ge;
    logic [DW-1:0]      n_rem;
    logic [VW-1:0]      n_v;
    logic [RW+3:0]      sq_t;
    logic [RW+3:0]      sq_trial;
    logic               sq_ge;
    logic [RW+1:0]      n_srem;
    logic [RW-1:0]      n_root;

    assign last = (r_cnt == CNTW'(1));

    // shared step datapath
    always_comb begin
        n_a    = (r_a << 1) + (r_mplier[SW-1] ? r_mcand : '0);
        dv_t   = {r_rem, r_v[VW-1]};
        dv_ge  = dv_t >= {1'b0, r_d};
        n_rem  = dv_ge ? DW'(dv_t - {1'b0, r_d}) : dv_t[DW-1:0];
        n_v    = {r_v[VW-2:0], dv_ge};
        sq_t     = {r_srem, r_v[VW-1:VW-2]};
        sq_trial = (RW+4)'({r_root, 2'b01});
        sq_ge    = sq_t >= sq_trial;
        n_srem   = sq_ge ? (RW+2)'(sq_t - sq_trial) : sq_t[RW+1:0];
        n_root   = {r_root[RW-2:0], sq_ge};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            AR_IDLE: if (i_start) n_state = AR_MDIV;
            AR_MDIV: if (last) n_state = (r_n < COUNT_W'(2)) ? AR_IDLE : AR_SQ;
            AR_SQ:   if (last) n_state = AR_NQ;
            AR_NQ:   if (last) n_state = AR_VDIV;
            AR_VDIV: if (last) n_state = AR_SQRT;
            AR_SQRT: if (last) n_state = AR_IDLE;
            default: n_state = AR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                AR_IDLE: begin
                    if (i_start) begin
                        r_n   <= i_count;
                        r_s   <= i_sum;
                        r_q   <= i_sqsum;
                        r_v   <= VW'(i_sum) << (VW - SW);
                        r_d   <= DW'(i_count);
                        r_rem <= '0;
                        r_cnt <= CNTW'(SW);
                    end
                end
                AR_MDIV: begin
                    r_v   <= n_v;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNTW'(1);
                    if (last) begin
                        r_mean   <= FIELD_W'(n_v[SW-1:0]);
                        r_a      <= '0;
                        r_mcand  <= VW'(r_s);
                        r_mplier <= r_s;
                        r_cnt    <= CNTW'(SW);
                        if (r_n < COUNT_W'(2)) begin
                            r_std  <= '0;
                            r_done <= 1'b1;
                        end
                    end
                end
                AR_SQ: begin
                    r_a      <= n_a;
                    r_mplier <= r_mplier << 1;
                    r_cnt    <= r_cnt - CNTW'(1);
                    if (last) begin
                        r_b      <= n_a;
                        r_a      <= '0;
                        r_mcand  <= VW'(r_q);
                        r_mplier <= SW'(r_n) << (SW - COUNT_W);
                        r_cnt    <= CNTW'(COUNT_W);
                    end
                end
                AR_NQ: begin
                    r_a      <= n_a;
                    r_mplier <= r_mplier << 1;
                    r_cnt    <= r_cnt - CNTW'(1);
                    if (last) begin
                        // n*q - s^2 is never negative
                        r_v   <= n_a - r_b;
                        r_rem <= '0;
                        r_d   <= DW'(r_n) * DW'(r_n - COUNT_W'(1));
                        r_cnt <= CNTW'(VW);
                    end
                end
                AR_VDIV: begin
                    r_v   <= n_v;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNTW'(1);
                    if (last) begin
                        r_srem <= '0;
                        r_root <= '0;
                        r_cnt  <= CNTW'(RW);
                    end
                end
                AR_SQRT: begin
                    r_v    <= r_v << 2;
                    r_srem <= n_srem;
                    r_root <= n_root;
                    r_cnt  <= r_cnt - CNTW'(1);
                    if (last) begin
                        r_std  <= FIELD_W'(n_root);
                        r_done <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_mean = r_mean;
    assign o_std  = r_std;
endmodule

// ===== sv/sliding_window_statistics.sv =====
// Sliding window statistics: mean, sample deviation, min and max over a ring window.
//
// Input channel: i_in_valid / o_in_stall carry one sample per transfer; only the
// low SAMPLE_BITS bits are used. Output channel: o_out_valid / i_out_stall carry
// mean, std_dev, minimum, maximum and sample_count, one result per sample.
// i_cfg_we / i_cfg_data write the window length (0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW); every write empties the window. Write only idle.
//
// The serial multiply / divide / root unit sets the time per sample; with one
// sample in the window it stops after the mean divide and gives zero deviation.
// The variance word is 64 bits at the defaults. The min/max walk over the
// window (through the memory read port) runs beside the arithmetic unit. One
// sample is in work at a time; the next is taken once the result sits in the
// output register. Reset empties the window and sets the length to 100. A stalled
// result holds in the output register; the following result waits behind it.
module sliding_window_statistics #(
    parameter int MAX_WINDOW  = 128,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sws_pkg::COUNT_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [sws_pkg::FIELD_W-1:0] i_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [sws_pkg::FIELD_W-1:0] o_mean,
    output logic [sws_pkg::FIELD_W-1:0] o_std_dev,
    output logic [sws_pkg::FIELD_W-1:0] o_minimum,
    output logic [sws_pkg::FIELD_W-1:0] o_maximum,
    output logic [sws_pkg::COUNT_W-1:0] o_sample_count
);
    import sws_pkg::*;

    localparam int PW   = $clog2(MAX_WINDOW);
    localparam int NMAX = (MAX_WINDOW < 255) ? MAX_WINDOW : 255;
    localparam int LW   = $clog2(NMAX + 1);
    localparam int SW   = SAMPLE_BITS + LW;
    localparam int QW   = 2*SAMPLE_BITS + LW;
    localparam int CMPW = (PW + 1 > COUNT_W) ? PW + 1 : COUNT_W;

    t_top_state r_state, n_state;

    logic [COUNT_W-1:0]     r_cfg;
    logic [PW-1:0]          r_wptr;
    logic [COUNT_W-1:0]     r_fill;
    logic [SW-1:0]          r_sum;
    logic [QW-1:0]          r_sq;
    logic [SAMPLE_BITS-1:0] r_x;
    logic [SAMPLE_BITS-1:0] r_old;
    logic [2*SAMPLE_BITS-1:0] r_xsq;
    logic [2*SAMPLE_BITS-1:0] r_osq;
    logic                   r_ar_done;
    logic                   r_mm_done;

    logic                   r_ovalid;
    logic [FIELD_W-1:0]     r_omean;
    logic [FIELD_W-1:0]     r_ostd;
    logic [FIELD_W-1:0]     r_omin;
    logic [FIELD_W-1:0]     r_omax;
    logic [COUNT_W-1:0]     r_ocount;

    logic [COUNT_W-1:0]     len;
    logic                   full;
    logic                   in_xfer;
    logic                   out_xfer;
    logic                   start;

    logic                   ram_we;
    logic                   ram_re;
    logic [PW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    logic                   mm_re;
    logic [PW-1:0]          mm_raddr;
    logic                   mm_done;
    logic [SAMPLE_BITS-1:0] mm_min;
    logic [SAMPLE_BITS-1:0] mm_max;
    logic                   ar_done;
    logic [FIELD_W-1:0]     ar_mean;
    logic [FIELD_W-1:0]     ar_std;

    // effective window length
    always_comb begin
        if (r_cfg == '0) begin
            len = COUNT_W'(1);
        end else if (CMPW'(r_cfg) > CMPW'(MAX_WINDOW)) begin
            len = COUNT_W'(MAX_WINDOW);
        end else begin
            len = r_cfg;
        end
    end

    assign full     = r_fill >= len;
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_ovalid && !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_xfer) n_state = ST_FETCH;
            ST_FETCH:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_LAUNCH;
            ST_LAUNCH: n_state = ST_RUN;
            ST_RUN:    if (r_ar_done && r_mm_done) n_state = ST_EMIT;
            ST_EMIT:   if (!r_ovalid || out_xfer) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        start      = (r_state == ST_LAUNCH);
        ram_we     = (r_state == ST_UPDATE);
        // slot being overwritten is fetched on the accept cycle
        if (r_state == ST_IDLE) begin
            ram_re    = in_xfer;
            ram_raddr = r_wptr;
        end else begin
            ram_re    = mm_re;
            ram_raddr = mm_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= LEN_RESET;
            r_wptr    <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_sq      <= '0;
            r_ar_done <= 1'b0;
            r_mm_done <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_xfer) r_ovalid <= 1'b0;

            if (i_cfg_we) begin
                r_cfg  <= i_cfg_data;
                r_wptr <= '0;
                r_fill <= '0;
                r_sum  <= '0;
                r_sq   <= '0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) r_x <= i_sample[SAMPLE_BITS-1:0];
                end
                ST_FETCH: begin
                    r_old <= ram_rdata;
                    r_xsq <= (2*SAMPLE_BITS)'(r_x) * (2*SAMPLE_BITS)'(r_x);
                    r_osq <= (2*SAMPLE_BITS)'(ram_rdata) * (2*SAMPLE_BITS)'(ram_rdata);
                end
                ST_UPDATE: begin
                    if (full) begin
                        r_sum <= r_sum - SW'(r_old) + SW'(r_x);
                        r_sq  <= r_sq - QW'(r_osq) + QW'(r_xsq);
                    end else begin
                        r_sum  <= r_sum + SW'(r_x);
                        r_sq   <= r_sq + QW'(r_xsq);
                        r_fill <= r_fill + COUNT_W'(1);
                    end
                    if (CMPW'(r_wptr) + CMPW'(1) >= CMPW'(len)) begin
                        r_wptr <= '0;
                    end else begin
                        r_wptr <= r_wptr + PW'(1);
                    end
                end
                ST_LAUNCH: begin
                    r_ar_done <= 1'b0;
                    r_mm_done <= 1'b0;
                end
                ST_RUN: begin
                    if (ar_done) r_ar_done <= 1'b1;
                    if (mm_done) r_mm_done <= 1'b1;
                end
                ST_EMIT: begin
                    if (!r_ovalid || out_xfer) begin
                        r_ovalid <= 1'b1;
                        r_omean  <= ar_mean;
                        r_ostd   <= ar_std;
                        r_omin   <= FIELD_W'(mm_min);
                        r_omax   <= FIELD_W'(mm_max);
                        r_ocount <= r_fill;
                    end
                end
                default: ;
            endcase
        end
    end

    sws_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (r_x),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sws_minmax #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_minmax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_count (r_fill),
        .o_re    (mm_re),
        .o_raddr (mm_raddr),
        .i_rdata (ram_rdata),
        .o_done  (mm_done),
        .o_min   (mm_min),
        .o_max   (mm_max)
    );

    sws_arith #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_count (r_fill),
        .i_sum   (r_sum),
        .i_sqsum (r_sq),
        .o_done  (ar_done),
        .o_mean  (ar_mean),
        .o_std   (ar_std)
    );

    assign o_out_valid    = r_ovalid;
    assign o_mean         = r_omean;
    assign o_std_dev      = r_ostd;
    assign o_minimum      = r_omin;
    assign o_maximum      = r_omax;
    assign o_sample_count = r_ocount;
endmodule

// ===== sv/sws_check.sv =====
// Port-level checks for the sliding window statistics block, bound to the top level.
module sws_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [sws_pkg::FIELD_W-1:0] o_mean,
    input logic [sws_pkg::FIELD_W-1:0] o_minimum,
    input logic [sws_pkg::FIELD_W-1:0] o_maximum,
    input logic [sws_pkg::COUNT_W-1:0] o_sample_count
);
    import sws_pkg::*;

    // one sample in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a sample is in work");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_mean)
            && $stable(o_minimum) && $stable(o_maximum) && $stable(o_sample_count)))
        else $error("stalled result changed");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_count != '0))
        else $error("result with empty window");

    a_mean_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_minimum <= o_mean && o_mean <= o_maximum))
        else $error("mean outside min/max");
endmodule

bind sliding_window_statistics sws_check u_sws_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_mean         (o_mean),
    .o_minimum      (o_minimum),
    .o_maximum      (o_maximum),
    .o_sample_count (o_sample_count)
);

// ===== bench/sliding_window_statistics_tb.sv =====
// Self-checking testbench for the sliding window statistics block.
`timescale 1ns / 1ps

module sliding_window_statistics_tb;
    import sws_pkg::*;

    localparam int MAX_WIN    = 128;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PEND_DEPTH  = 256;

    typedef struct packed {
        logic [FIELD_W-1:0] mean;
        logic [FIELD_W-1:0] std_dev;
        logic [FIELD_W-1:0] minimum;
        logic [FIELD_W-1:0] maximum;
        logic [COUNT_W-1:0] sample_count;
    } t_stats;

    // Directed row: sample, and optional typed-in expectation.
    typedef struct {
        logic [FIELD_W-1:0] sample;
        bit                 typed;
        t_stats             stats;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [FIELD_W-1:0] i_sample;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [FIELD_W-1:0] o_mean;
    logic [FIELD_W-1:0] o_std_dev;
    logic [FIELD_W-1:0] o_minimum;
    logic [FIELD_W-1:0] o_maximum;
    logic [COUNT_W-1:0] o_sample_count;

    sliding_window_statistics u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_mean         (o_mean),
        .o_std_dev      (o_std_dev),
        .o_minimum      (o_minimum),
        .o_maximum      (o_maximum),
        .o_sample_count (o_sample_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Shadow of the block state, kept by the predictor.
    logic [COUNT_W-1:0] win_len;
    logic [FIELD_W-1:0] win_samples [MAX_WIN];
    int unsigned        wr_ptr;
    int unsigned        fill;
    logic [63:0]        sum_acc;
    logic [63:0]        sq_acc;

    // Expected results in transfer order: written by the sender, read by the receiver.
    t_stats       pend_buf [PEND_DEPTH];
    int unsigned  pend_wr = 0;
    int unsigned  pend_rd = 0;
    int      error_count;
    longint  cycle_count = 0;
    int      send_idle_pct;   // percent of cycles the sender holds off
    int      recv_stall_pct;  // percent of cycles the receiver stalls

    function automatic void clear_window();
        wr_ptr  = 0;
        fill    = 0;
        sum_acc = '0;
        sq_acc  = '0;
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Sample deviation via s = n*m + r, so nothing overflows 64 bits.
    function automatic logic [63:0] sample_deviation(int unsigned n, logic [63:0] s,
                                                     logic [63:0] q);
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] dev_sq;
        logic [63:0] part;
        if (n < 2) return '0;
        m      = s / n;
        r      = s % n;
        dev_sq = q - n * m * m - 2 * m * r;
        part   = (r * r + n - 1) / n;
        if (dev_sq < part) return '0;
        return isqrt64((dev_sq - part) / (n - 1));
    endfunction

    // Advance the shadow window by one sample and return the expected stats.
    function automatic t_stats window_stats(logic [FIELD_W-1:0] x);
        t_stats      st;
        int unsigned len;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        logic [63:0] old;
        len = (win_len == 0) ? 1 : (win_len > MAX_WIN) ? MAX_WIN : win_len;
        if (fill >= len) begin
            old     = win_samples[wr_ptr];
            sum_acc = sum_acc - old;
            sq_acc  = sq_acc - old * old;
        end else begin
            fill++;
        end
        win_samples[wr_ptr] = x;
        sum_acc = sum_acc + x;
        sq_acc  = sq_acc + 64'(x) * 64'(x);
        wr_ptr  = (wr_ptr + 1 >= len) ? 0 : wr_ptr + 1;
        lo = win_samples[0];
        hi = win_samples[0];
        for (int i = 1; i < fill; i++) begin
            if (win_samples[i] < lo) lo = win_samples[i];
            if (win_samples[i] > hi) hi = win_samples[i];
        end
        st.mean         = FIELD_W'(sum_acc / fill);
        st.std_dev      = FIELD_W'(sample_deviation(fill, sum_acc, sq_acc));
        st.minimum      = lo;
        st.maximum      = hi;
        st.sample_count = COUNT_W'(fill);
        return st;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Output side: random stall, compare each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pend_rd == pend_wr) begin
                    $display("ERROR @%0t: result with nothing pending", $realtime);
                    error_count++;
                end else begin
                    t_stats w;
                    w = pend_buf[pend_rd % PEND_DEPTH];
                    pend_rd++;
                    if (o_mean !== w.mean) report_mismatch("mean", o_mean, w.mean);
                    if (o_std_dev !== w.std_dev)
                        report_mismatch("std_dev", o_std_dev, w.std_dev);
                    if (o_minimum !== w.minimum)
                        report_mismatch("minimum", o_minimum, w.minimum);
                    if (o_maximum !== w.maximum)
                        report_mismatch("maximum", o_maximum, w.maximum);
                    if (o_sample_count !== w.sample_count)
                        report_mismatch("sample_count", o_sample_count, w.sample_count);
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Cycle limit: a hang ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sliding_window_statistics regression: fail");
            $finish;
        end
    end

    // One input transfer; the predictor runs when the transfer is accepted.
    // Valid stays high afterwards so the next sample can follow at once.
    task automatic send_sample(logic [FIELD_W-1:0] x, output t_stats st);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_sample   <= FIELD_W'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        st = window_stats(x);
        pend_buf[pend_wr % PEND_DEPTH] = st;
        pend_wr++;
    endtask

    // Sender goes quiet until every expected result has come.
    task automatic hold_input();
        i_in_valid <= 1'b0;
        while (pend_rd != pend_wr) @(posedge i_clk);
    endtask

    // Wait for every result, then let the block settle past its latency.
    task automatic drain();
        hold_input();
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_length(logic [COUNT_W-1:0] len);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        win_len = len;
        clear_window();
    endtask

    function automatic t_row row_free(logic [FIELD_W-1:0] x);
        t_row r;
        r.sample = x;
        r.typed  = 1'b0;
        return r;
    endfunction

    function automatic t_row row_typed(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] mn,
                                       logic [FIELD_W-1:0] sd, logic [FIELD_W-1:0] lo,
                                       logic [FIELD_W-1:0] hi, logic [COUNT_W-1:0] n);
        t_row r;
        r.sample             = x;
        r.typed              = 1'b1;
        r.stats.mean         = mn;
        r.stats.std_dev      = sd;
        r.stats.minimum      = lo;
        r.stats.maximum      = hi;
        r.stats.sample_count = n;
        return r;
    endfunction

    // Random sample: full range half the time, else clustered or at the extremes.
    function automatic logic [FIELD_W-1:0] rand_sample();
        case ($urandom_range(5))
            0:       return '1;
            1:       return FIELD_W'($urandom_range(15));
            2:       return 24'd5000 + FIELD_W'($urandom_range(40));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] rand_length();
        case ($urandom_range(5))
            0:       return COUNT_W'($urandom_range(2, 6));
            1:       return COUNT_W'($urandom_range(129, 255));
            default: return COUNT_W'($urandom_range(1, 24));
        endcase
    endfunction

    initial begin
        t_row   rows[6];
        t_stats got;
        int     sent;

        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_sample       = '0;
        win_len        = LEN_RESET;
        clear_window();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: window length at reset, first samples are readable by eye.
        rows[0] = row_typed(24'hFFFFFF, 24'hFFFFFF, 0, 24'hFFFFFF, 24'hFFFFFF, 1);
        rows[1] = row_typed(24'h000000, 24'h7FFFFF, 24'hB504F2, 0, 24'hFFFFFF, 2);
        rows[2] = row_free(24'h000001);
        rows[3] = row_free(24'h800000);
        rows[4] = row_free(24'h555555);
        rows[5] = row_free(24'hAAAAAA);
        foreach (rows[i]) begin
            send_sample(rows[i].sample, got);
            if (rows[i].typed && got != rows[i].stats) begin
                $display("ERROR: directed row %0d predictor disagrees", i);
                error_count++;
            end
        end

        // Zero length acts as one: every result covers just that sample.
        write_length(8'd0);
        send_sample(24'h123456, got);
        send_sample(24'hFFFFFF, got);
        // Length too large clamps to the maximum; fill past the wrap.
        write_length(8'd255);
        for (int i = 0; i < 132; i++) send_sample(FIELD_W'(i * 131071), got);
        // Constant samples in a short window give zero deviation.
        write_length(8'd3);
        repeat (5) send_sample(24'h00ABCD, got);
        write_length(8'd128);
        send_sample('0, got);
        send_sample('1, got);

        // Random phases under three idling profiles.
        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 6 : (phase == 1) ? 48 : 0;
            recv_stall_pct = (phase == 0) ? 48 : (phase == 1) ? 6 : 0;
            for (int k = 0; k < 4; k++) begin
                write_length(rand_length());
                repeat ($urandom_range(20, 30)) begin
                    send_sample(rand_sample(), got);
                    sent++;
                    // Hold off until the pipe is empty once in a while.
                    if (sent % 97 == 0) hold_input();
                end
            end
        end
        write_length(8'd1);
        send_sample(rand_sample(), got);
        send_sample(rand_sample(), got);

        drain();
        if (error_count == 0) begin
            $display("sliding_window_statistics regression: pass");
        end else begin
            $display("sliding_window_statistics regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/sws_pkg.sv
sv/sws_ram.sv
sv/sws_minmax.sv
sv/sws_arith.sv
sv/sliding_window_statistics.sv
sv/sws_check.sv
bench/sliding_window_statistics_tb.sv
